/* src/anf_quadratic_check_core_assert.svh */
// ----------------------------------------------------------------------------
// ANF quadratic check assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ANF_QUADRATIC_CHECK_CORE_ASSERT_SVH
`define ANF_QUADRATIC_CHECK_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define ANFQC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

`define ANFQC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define ANFQC_ASSERT(lbl, clk, rst_n, prop)

`define ANFQC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/anfqc_pkg.sv */
// ----------------------------------------------------------------------------
// ANF quadratic check package
// Item types and fixed codes shared by the core and its submodules.
// ----------------------------------------------------------------------------
package anfqc_pkg;

    localparam int CFG_W     = 4;
    localparam int MIN_BITS  = 2;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic KIND_CHECK = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] entry_index;
        logic [7:0] entry_value;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] coefficient;
        logic       low_degree;
    } t_out_item;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_seq_stat;

endpackage

/* src/anfqc_alu.sv */
// ----------------------------------------------------------------------------
// ANF quadratic check shared unit
// Butterfly xor for the transform and the per-entry degree test.
// ----------------------------------------------------------------------------
module anfqc_alu
    import anfqc_pkg::*;
#(
    parameter int AW = 8
) (
    input  logic [7:0]    i_word_a,
    input  logic [7:0]    i_word_b,
    input  logic [AW-1:0] i_index,
    output logic [7:0]    o_sum,
    output logic          o_violation
);

    logic [AW-1:0] clr1;
    logic [AW-1:0] clr2;

    // Clearing the lowest set bit twice leaves a nonzero value only when
    // the index has more than two set bits.
    assign clr1 = i_index & (i_index - AW'(1));
    assign clr2 = clr1 & (clr1 - AW'(1));

    assign o_sum       = i_word_a ^ i_word_b;
    assign o_violation = (|clr2) && (|i_word_a);

endmodule

/* src/anfqc_seq.sv */
// ----------------------------------------------------------------------------
// ANF quadratic check sequencer
// Coefficient table, transform walk and degree scan around the shared unit.
// ----------------------------------------------------------------------------
`include "anf_quadratic_check_core_assert.svh"

module anfqc_seq
    import anfqc_pkg::*;
#(
    parameter int AW = 8,
    parameter int NW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  t_in_item      i_cmd,
    input  logic [NW-1:0] i_n,
    output t_seq_stat     o_stat,
    output t_out_item     o_res
);

    localparam int PW    = (AW > 1) ? $clog2(AW) : 1;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_XFORM = 6'b000100,
        S_DRAIN = 6'b001000,
        S_CHECK = 6'b010000,
        S_CFIN  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [PW-1:0] r_pass, n_pass;
    logic [AW-1:0] r_walk, n_walk;
    logic          r_wr_pend, n_wr_pend;
    logic [AW-1:0] r_wr_addr, n_wr_addr;
    logic          r_chk_pend, n_chk_pend;
    logic [AW-1:0] r_chk_addr, n_chk_addr;
    logic          r_acc, n_acc;
    logic          r_quad, n_quad;

    logic [7:0]    r_coef [DEPTH];
    logic [7:0]    r_rd_a;
    logic [7:0]    r_rd_b;

    logic [AW-1:0] mask;
    logic [AW-1:0] pair_last;
    logic [AW-1:0] slot;
    logic [AW-1:0] bit_sel;
    logic [AW-1:0] low_mask;
    logic [AW-1:0] lo_addr;
    logic [AW-1:0] hi_addr;
    logic [PW-1:0] pass_last;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr_a;

    logic [7:0]    alu_sum;
    logic          alu_viol;
    logic          scan_ok;

    assign mask      = ~({AW{1'b1}} << i_n);
    assign pair_last = mask >> 1;
    assign pass_last = PW'(i_n - NW'(1));
    assign slot      = AW'(i_cmd.entry_index) & mask;

    // Pair number k becomes the lower index by opening a zero at the pass bit.
    assign bit_sel  = AW'(1) << r_pass;
    assign low_mask = bit_sel - AW'(1);
    assign lo_addr  = ((r_walk & ~low_mask) << 1) | (r_walk & low_mask);
    assign hi_addr  = lo_addr | bit_sel;

    anfqc_alu #(
        .AW (AW)
    ) u_alu (
        .i_word_a    (r_rd_a),
        .i_word_b    (r_rd_b),
        .i_index     (r_chk_addr),
        .o_sum       (alu_sum),
        .o_violation (alu_viol)
    );

    assign scan_ok = r_acc && !(r_chk_pend && alu_viol);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr_addr;
        mem_wdata = alu_sum;
        if (r_state == S_IDLE && i_cmd_valid && i_cmd.action == ACT_LOAD) begin
            mem_we    = 1'b1;
            mem_waddr = slot;
            mem_wdata = i_cmd.entry_value;
        end else if (r_wr_pend) begin
            mem_we = 1'b1;
        end
        case (r_state)
            S_XFORM: mem_raddr_a = lo_addr;
            S_CHECK: mem_raddr_a = r_walk;
            default: mem_raddr_a = slot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_coef[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_coef[mem_raddr_a];
        r_rd_b <= r_coef[hi_addr];
    end

    always_comb begin
        n_state    = r_state;
        n_pass     = r_pass;
        n_walk     = r_walk;
        n_wr_pend  = 1'b0;
        n_wr_addr  = r_wr_addr;
        n_chk_pend = 1'b0;
        n_chk_addr = r_chk_addr;
        n_acc      = r_acc;
        n_quad     = r_quad;
        o_stat     = '{idle: 1'b0, res_valid: 1'b0};
        o_res      = '{result_kind: KIND_READ, coefficient: r_rd_a, low_degree: r_quad};
        case (r_state)
            S_IDLE: begin
                o_stat.idle = 1'b1;
                if (i_cmd_valid) begin
                    if (i_cmd.action == ACT_READ) begin
                        n_state = S_READ;
                    end else if (i_cmd.is_last) begin
                        n_state = S_XFORM;
                        n_pass  = '0;
                        n_walk  = '0;
                    end
                end
            end
            S_READ: begin
                o_stat.res_valid = 1'b1;
                n_state          = S_IDLE;
            end
            S_XFORM: begin
                n_wr_pend = 1'b1;
                n_wr_addr = hi_addr;
                if (r_walk == pair_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_walk = r_walk + AW'(1);
                end
            end
            S_DRAIN: begin
                // The last butterfly of the pass is written here, before the
                // next pass reads anything.
                n_walk = '0;
                if (r_pass == pass_last) begin
                    n_state = S_CHECK;
                    n_acc   = 1'b1;
                end else begin
                    n_state = S_XFORM;
                    n_pass  = r_pass + PW'(1);
                end
            end
            S_CHECK: begin
                n_acc      = scan_ok;
                n_chk_pend = 1'b1;
                n_chk_addr = r_walk;
                if (r_walk == mask) begin
                    n_state = S_CFIN;
                end else begin
                    n_walk = r_walk + AW'(1);
                end
            end
            S_CFIN: begin
                n_quad           = scan_ok;
                o_stat.res_valid = 1'b1;
                o_res            = '{result_kind: KIND_CHECK, coefficient: 8'd0,
                                     low_degree: scan_ok};
                n_pass           = '0;
                n_walk           = '0;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pass     <= '0;
            r_walk     <= '0;
            r_wr_pend  <= 1'b0;
            r_chk_pend <= 1'b0;
            r_acc      <= 1'b1;
            r_quad     <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_pass     <= n_pass;
            r_walk     <= n_walk;
            r_wr_pend  <= n_wr_pend;
            r_chk_pend <= n_chk_pend;
            r_acc      <= n_acc;
            r_quad     <= n_quad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr  <= n_wr_addr;
        r_chk_addr <= n_chk_addr;
    end

    `ANFQC_ASSERT(a_idle_no_wr, i_clk, i_rst_n, (r_state == S_IDLE) |-> !r_wr_pend)
    `ANFQC_ASSERT_NEXT(a_pass_end, i_clk, i_rst_n, (r_state == S_XFORM && r_walk == pair_last), (r_state == S_DRAIN))
    `ANFQC_ASSERT(a_check_pass, i_clk, i_rst_n, (r_state == S_CHECK) |-> (r_pass == pass_last))

endmodule

/* src/anf_quadratic_check_core.sv */
// A load is written to the table on acceptance; a read's item passes through the
// table's read register and then the output register. A load marked last starts the
// transform, one butterfly per cycle within a pass through the table's two read ports.
// New items are taken only while the sequencer is idle and the output slot is free or being taken.
// Reset (synchronous, active low) clears control, sets n to 8 and the flag to one;
// the table is not cleared.
// ----------------------------------------------------------------------------
// ANF quadratic check core
// Loads an S-box table, transforms it to algebraic normal form in place,
// reports whether its degree is at most two and reads back coefficients.
// ----------------------------------------------------------------------------
`include "anf_quadratic_check_core_assert.svh"

module anf_quadratic_check_core
    import anfqc_pkg::*;
#(
    parameter int MAX_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    localparam int NW = $clog2(MAX_BITS + 1);

    logic [CFG_W-1:0] r_cfg;
    logic [NW-1:0]    act_n;
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic             in_acc;
    t_seq_stat        seq_stat;
    t_out_item        seq_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (int'(r_cfg) < MIN_BITS) begin
            act_n = NW'(MIN_BITS);
        end else if (int'(r_cfg) > MAX_BITS) begin
            act_n = NW'(MAX_BITS);
        end else begin
            act_n = NW'(r_cfg);
        end
    end

    assign o_in_ready = seq_stat.idle && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    anfqc_seq #(
        .AW (MAX_BITS),
        .NW (NW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (in_acc),
        .i_cmd       (i_in_item),
        .i_n         (act_n),
        .o_stat      (seq_stat),
        .o_res       (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_stat.res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_stat.res_valid) begin
            r_out_item <= seq_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `ANFQC_ASSERT_NEXT(a_read_busy, i_clk, i_rst_n, (in_acc && i_in_item.action == ACT_READ), !o_in_ready)
    `ANFQC_ASSERT(a_res_slot_free, i_clk, i_rst_n, seq_stat.res_valid |-> !r_out_valid)
    `ANFQC_ASSERT(a_n_range, i_clk, i_rst_n, (int'(act_n) >= MIN_BITS) && (int'(act_n) <= MAX_BITS))

endmodule
